// File: hdl/ecam_pkg.sv
package ecam_pkg;

    // Fixed-point formats
    localparam int ANGLE_FRAC_BITS  = 7;
    localparam int VECTOR_FRAC_BITS = 14;
    localparam int CORDIC_STEPS     = 16;

    localparam int IN_W      = 16;
    localparam int PITCH_W   = 15;
    localparam int YAW_W     = 16;
    localparam int SUM_W     = 18;
    localparam int ANG_W     = 16;
    localparam int ANG_Q     = 24;
    localparam int Z_W       = 34;
    localparam int XY_W      = 34;
    localparam int CQ        = 30;
    localparam int TRIG_W    = 32;
    localparam int PROD_W    = 64;
    localparam int OUT_W     = VECTOR_FRAC_BITS + 2;
    localparam int STEP_IDX_W = 5;

    // Angle limits, degrees scaled by 2^ANGLE_FRAC_BITS
    localparam int PITCH_LIMIT  = 89 << ANGLE_FRAC_BITS;
    localparam int FULL_TURN    = 360 << ANGLE_FRAC_BITS;
    localparam int HALF_TURN    = 180 << ANGLE_FRAC_BITS;
    localparam int QUARTER_TURN = 90 << ANGLE_FRAC_BITS;

    localparam int OUT_ONE = 1 << VECTOR_FRAC_BITS;

    localparam logic signed [XY_W-1:0]   CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [Z_W-1:0]    RAD_DEG     = 34'sd961263669;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE    = TRIG_W'(longint'(1) << CQ);

    // Opcodes
    localparam logic OP_ROTATE = 1'b0;
    localparam logic OP_SET    = 1'b1;

    typedef struct packed {
        logic                    opcode;
        logic signed [IN_W-1:0]  pitch_in;
        logic signed [IN_W-1:0]  yaw_in;
    } t_cmd;

    typedef struct packed {
        logic signed [OUT_W-1:0] front_x;
        logic signed [OUT_W-1:0] front_y;
        logic signed [OUT_W-1:0] front_z;
        logic signed [OUT_W-1:0] right_x;
        logic signed [OUT_W-1:0] right_z;
        logic signed [OUT_W-1:0] up_x;
        logic signed [OUT_W-1:0] up_y;
        logic signed [OUT_W-1:0] up_z;
    } t_basis;

    typedef struct packed {
        logic                    start;
        logic signed [ANG_W-1:0] angle;
    } t_cordic_ctl;

    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] sin_q;
        logic signed [TRIG_W-1:0] cos_q;
    } t_cordic_sts;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sp;
        logic signed [TRIG_W-1:0] cp;
        logic signed [TRIG_W-1:0] sy;
        logic signed [TRIG_W-1:0] cy;
    } t_trig;

    // Arctangent of 2^-idx in degrees, 24 fraction bits
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 34'sd754974720;
            5'd1:    v = 34'sd445687602;
            5'd2:    v = 34'sd235489088;
            5'd3:    v = 34'sd119537938;
            5'd4:    v = 34'sd60000934;
            5'd5:    v = 34'sd30029717;
            5'd6:    v = 34'sd15018523;
            5'd7:    v = 34'sd7509720;
            5'd8:    v = 34'sd3754917;
            5'd9:    v = 34'sd1877466;
            default: v = RAD_DEG >>> idx;
        endcase
        return v;
    endfunction

    // Saturate to a unit vector component
    function automatic logic signed [OUT_W-1:0] clamp_out(input logic signed [PROD_W:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > OUT_ONE) begin
            r = OUT_W'(OUT_ONE);
        end else if (v < -OUT_ONE) begin
            r = OUT_W'(-OUT_ONE);
        end else begin
            r = OUT_W'(v);
        end
        return r;
    endfunction

    // Round half up from Q30 to the vector format
    function automatic logic signed [OUT_W-1:0] rnd_single(input logic signed [TRIG_W-1:0] v);
        logic signed [TRIG_W:0] s;
        s = (TRIG_W+1)'(v) + ((TRIG_W+1)'(1) <<< (CQ - VECTOR_FRAC_BITS - 1));
        s = s >>> (CQ - VECTOR_FRAC_BITS);
        return clamp_out((PROD_W+1)'(s));
    endfunction

    // Round half up from Q60 to the vector format
    function automatic logic signed [OUT_W-1:0] rnd_product(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W:0] s;
        s = (PROD_W+1)'(v) + ((PROD_W+1)'(1) <<< (2 * CQ - VECTOR_FRAC_BITS - 1));
        s = s >>> (2 * CQ - VECTOR_FRAC_BITS);
        return clamp_out(s);
    endfunction

endpackage

// File: hdl/ecam_ifs.sv
interface ecam_cmd_if;
    logic              valid;
    logic              ready;
    ecam_pkg::t_cmd    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ecam_basis_if;
    logic              valid;
    logic              ready;
    ecam_pkg::t_basis  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/euler_camera_orientation_top.sv
// First-person camera orientation. Each command item either adds pitch and yaw
// deltas to the held angles or loads absolute angles (degrees x 128); pitch
// saturates at +/-89 degrees and yaw wraps into one turn. Every command returns
// one item with the front, right and up unit vectors in signed Q1.14 (right.y is
// always zero and not carried). One CORDIC rotation unit is run twice per command,
// pitch then yaw, followed by a single multiplier that forms the four cross
// products; the result is then loaded into the output register and offered. The
// command port is ready only while no command is in flight; a finished result
// waits in the output register, so the next command may be accepted before it
// is taken.
module euler_camera_orientation_top #(
    parameter int CORDIC_STEPS = ecam_pkg::CORDIC_STEPS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ecam_cmd_if.sink      i_cmd,
    ecam_basis_if.source  o_vec
);

    typedef enum logic [2:0] {
        S_IDLE, S_START_P, S_WAIT_P, S_WAIT_Y, S_WAIT_B, S_LOAD
    } t_state;

    t_state                               r_state;
    logic signed [ecam_pkg::TRIG_W-1:0]   r_sp, r_cp;
    logic                                 r_out_valid, n_out_valid;
    ecam_pkg::t_basis                     r_out;

    logic                                 accept;
    logic signed [ecam_pkg::ANG_W-1:0]    pitch;
    logic signed [ecam_pkg::ANG_W-1:0]    yaw_fold;
    ecam_pkg::t_cordic_ctl                cordic_ctl;
    ecam_pkg::t_cordic_sts                cordic_sts;
    ecam_pkg::t_trig                      trig;
    logic                                 basis_start;
    logic                                 basis_done;
    ecam_pkg::t_basis                     basis;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;

    ecam_angle u_angle (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_cmd      (i_cmd.data),
        .o_pitch    (pitch),
        .o_yaw_fold (yaw_fold)
    );

    // Pitch first, then yaw as soon as pitch is done
    always_comb begin
        cordic_ctl.start = (r_state == S_START_P) || ((r_state == S_WAIT_P) && cordic_sts.done);
        cordic_ctl.angle = (r_state == S_START_P) ? pitch : yaw_fold;
    end

    ecam_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cordic_ctl),
        .o_sts   (cordic_sts)
    );

    always_comb begin
        trig.sp     = r_sp;
        trig.cp     = r_cp;
        trig.sy     = cordic_sts.sin_q;
        trig.cy     = cordic_sts.cos_q;
        basis_start = (r_state == S_WAIT_Y) && cordic_sts.done;
    end

    ecam_basis u_basis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (basis_start),
        .i_trig  (trig),
        .o_done  (basis_done),
        .o_basis (basis)
    );

    // Raise valid on load, drop it once the item is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && o_vec.ready) begin
            n_out_valid = 1'b0;
        end
        if ((r_state == S_LOAD) && (!r_out_valid || o_vec.ready)) begin
            n_out_valid = 1'b1;
        end
    end

    // Sequence one command and hold its result in the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_START_P;
                    end
                end
                S_START_P: r_state <= S_WAIT_P;
                S_WAIT_P: begin
                    if (cordic_sts.done) begin
                        r_sp    <= cordic_sts.sin_q;
                        r_cp    <= cordic_sts.cos_q;
                        r_state <= S_WAIT_Y;
                    end
                end
                S_WAIT_Y: begin
                    if (cordic_sts.done) begin
                        r_state <= S_WAIT_B;
                    end
                end
                S_WAIT_B: begin
                    if (basis_done) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (!r_out_valid || o_vec.ready) begin
                        r_out   <= basis;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_vec.valid = r_out_valid;
    assign o_vec.data  = r_out;

    a_basis_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        basis_done |-> (r_state == S_WAIT_B))
        else $error("vector result outside its wait state");

    a_load_offers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LOAD) && (!r_out_valid || o_vec.ready))
            |=> (o_vec.valid && (r_state == S_IDLE)))
        else $error("result not offered after load");

endmodule

// File: hdl/ecam_angle.sv
module ecam_angle (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_load,
    input  ecam_pkg::t_cmd                        i_cmd,
    output logic signed [ecam_pkg::ANG_W-1:0]     o_pitch,
    output logic signed [ecam_pkg::ANG_W-1:0]     o_yaw_fold
);

    logic signed [ecam_pkg::PITCH_W-1:0] r_pitch, n_pitch;
    logic        [ecam_pkg::YAW_W-1:0]   r_yaw, n_yaw;

    logic signed [ecam_pkg::SUM_W-1:0]   p_sum;
    logic signed [ecam_pkg::SUM_W-1:0]   y_sum;
    logic signed [ecam_pkg::SUM_W-1:0]   y_wrap;
    logic signed [ecam_pkg::YAW_W:0]     yaw_s;

    // Add deltas or take absolute angles
    always_comb begin
        if (i_cmd.opcode == ecam_pkg::OP_ROTATE) begin
            p_sum = ecam_pkg::SUM_W'(i_cmd.pitch_in) + ecam_pkg::SUM_W'(r_pitch);
            y_sum = ecam_pkg::SUM_W'(i_cmd.yaw_in)
                  + signed'(ecam_pkg::SUM_W'(r_yaw));
        end else begin
            p_sum = ecam_pkg::SUM_W'(i_cmd.pitch_in);
            y_sum = ecam_pkg::SUM_W'(i_cmd.yaw_in);
        end
    end

    // Saturate pitch
    always_comb begin
        if (p_sum > ecam_pkg::PITCH_LIMIT) begin
            n_pitch = ecam_pkg::PITCH_W'(ecam_pkg::PITCH_LIMIT);
        end else if (p_sum < -ecam_pkg::PITCH_LIMIT) begin
            n_pitch = ecam_pkg::PITCH_W'(-ecam_pkg::PITCH_LIMIT);
        end else begin
            n_pitch = ecam_pkg::PITCH_W'(p_sum);
        end
    end

    // Wrap yaw into one turn; the sum never leaves (-1, 2) turns
    always_comb begin
        if (y_sum < 0) begin
            y_wrap = ecam_pkg::SUM_W'(y_sum + ecam_pkg::FULL_TURN);
        end else if (y_sum >= ecam_pkg::FULL_TURN) begin
            y_wrap = ecam_pkg::SUM_W'(y_sum - ecam_pkg::FULL_TURN);
        end else begin
            y_wrap = y_sum;
        end
        n_yaw = ecam_pkg::YAW_W'(y_wrap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= '0;
            r_yaw   <= '0;
        end else if (i_load) begin
            r_pitch <= n_pitch;
            r_yaw   <= n_yaw;
        end
    end

    // Present yaw as a signed half-turn range
    always_comb begin
        yaw_s = signed'({1'b0, r_yaw});
        if (r_yaw > ecam_pkg::HALF_TURN) begin
            o_yaw_fold = ecam_pkg::ANG_W'(yaw_s - ecam_pkg::FULL_TURN);
        end else begin
            o_yaw_fold = ecam_pkg::ANG_W'(yaw_s);
        end
    end

    assign o_pitch = ecam_pkg::ANG_W'(r_pitch);

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pitch <= ecam_pkg::PITCH_LIMIT) && (r_pitch >= -ecam_pkg::PITCH_LIMIT))
        else $error("pitch outside limit");

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_yaw < ecam_pkg::FULL_TURN))
        else $error("yaw not wrapped");

endmodule

// File: hdl/ecam_cordic.sv
module ecam_cordic #(
    parameter int STEPS = ecam_pkg::CORDIC_STEPS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ecam_pkg::t_cordic_ctl  i_ctl,
    output ecam_pkg::t_cordic_sts  o_sts
);

    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_ITER, S_FIN} t_state;

    t_state                               r_state;
    logic signed [ecam_pkg::XY_W-1:0]     r_x, r_y;
    logic signed [ecam_pkg::Z_W-1:0]      r_z;
    logic        [CNT_W-1:0]              r_cnt;
    logic                                 r_neg;
    logic                                 r_done;
    logic signed [ecam_pkg::TRIG_W-1:0]   r_sin, r_cos;

    logic signed [ecam_pkg::ANG_W-1:0]    a_fold;
    logic                                 fold_neg;
    logic signed [ecam_pkg::Z_W-1:0]      z_start;
    logic signed [ecam_pkg::XY_W-1:0]     dx, dy;
    logic signed [ecam_pkg::Z_W-1:0]      at;
    logic signed [ecam_pkg::XY_W-1:0]     n_x, n_y;
    logic signed [ecam_pkg::Z_W-1:0]      n_z;
    logic signed [ecam_pkg::TRIG_W-1:0]   x_cl, y_cl;

    // Fold the angle into a quarter turn either side of zero
    always_comb begin
        if (i_ctl.angle > ecam_pkg::QUARTER_TURN) begin
            a_fold   = ecam_pkg::ANG_W'(i_ctl.angle - ecam_pkg::HALF_TURN);
            fold_neg = 1'b1;
        end else if (i_ctl.angle < -ecam_pkg::QUARTER_TURN) begin
            a_fold   = ecam_pkg::ANG_W'(i_ctl.angle + ecam_pkg::HALF_TURN);
            fold_neg = 1'b1;
        end else begin
            a_fold   = i_ctl.angle;
            fold_neg = 1'b0;
        end
        z_start = ecam_pkg::Z_W'(a_fold) <<< (ecam_pkg::ANG_Q - ecam_pkg::ANGLE_FRAC_BITS);
    end

    // One micro-rotation
    always_comb begin
        dx = r_y >>> r_cnt;
        dy = r_x >>> r_cnt;
        at = ecam_pkg::atan_entry(ecam_pkg::STEP_IDX_W'(r_cnt));
        if (!r_z[ecam_pkg::Z_W-1]) begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - at;
        end else begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + at;
        end
    end

    // Saturate to plus or minus one
    always_comb begin
        if (r_x > ecam_pkg::TRIG_ONE) begin
            x_cl = ecam_pkg::TRIG_ONE;
        end else if (r_x < -ecam_pkg::TRIG_ONE) begin
            x_cl = -ecam_pkg::TRIG_ONE;
        end else begin
            x_cl = ecam_pkg::TRIG_W'(r_x);
        end
        if (r_y > ecam_pkg::TRIG_ONE) begin
            y_cl = ecam_pkg::TRIG_ONE;
        end else if (r_y < -ecam_pkg::TRIG_ONE) begin
            y_cl = -ecam_pkg::TRIG_ONE;
        end else begin
            y_cl = ecam_pkg::TRIG_W'(r_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_FIN);
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_x     <= ecam_pkg::CORDIC_GAIN;
                        r_y     <= '0;
                        r_z     <= z_start;
                        r_neg   <= fold_neg;
                        r_cnt   <= '0;
                        r_state <= S_ITER;
                    end
                end
                S_ITER: begin
                    r_x   <= n_x;
                    r_y   <= n_y;
                    r_z   <= n_z;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(STEPS - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_cos   <= r_neg ? -x_cl : x_cl;
                    r_sin   <= r_neg ? -y_cl : y_cl;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_sts.done  = r_done;
    assign o_sts.sin_q = r_sin;
    assign o_sts.cos_q = r_cos;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> (r_state == S_IDLE))
        else $error("rotation started while busy");

endmodule

// File: hdl/ecam_basis.sv
module ecam_basis (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ecam_pkg::t_trig   i_trig,
    output logic              o_done,
    output ecam_pkg::t_basis  o_basis
);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    // Product slots in issue order
    localparam logic [2:0] P_FRONT_X = 3'd0;
    localparam logic [2:0] P_FRONT_Z = 3'd1;
    localparam logic [2:0] P_UP_X    = 3'd2;
    localparam logic [2:0] P_UP_Z    = 3'd3;
    localparam logic [2:0] P_END     = 3'd4;

    t_state                                r_state;
    logic        [2:0]                     r_idx;
    logic signed [ecam_pkg::PROD_W-1:0]    r_prod;
    logic                                  r_done;
    ecam_pkg::t_basis                      r_basis;

    logic signed [ecam_pkg::TRIG_W-1:0]    op_a, op_b;
    logic signed [ecam_pkg::PROD_W-1:0]    mul;
    logic signed [ecam_pkg::OUT_W-1:0]     prod_rnd;

    // Select the operand pair for the shared multiplier
    always_comb begin
        unique case (r_idx)
            P_FRONT_X: begin op_a = i_trig.cy;  op_b = i_trig.cp; end
            P_FRONT_Z: begin op_a = i_trig.sy;  op_b = i_trig.cp; end
            P_UP_X:    begin op_a = -i_trig.cy; op_b = i_trig.sp; end
            P_UP_Z:    begin op_a = -i_trig.sy; op_b = i_trig.sp; end
            default:   begin op_a = '0;         op_b = '0;        end
        endcase
        mul      = op_a * op_b;
        prod_rnd = ecam_pkg::rnd_product(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_idx   <= P_FRONT_X;
        end else begin
            r_done <= (r_state == S_RUN) && (r_idx == P_END);
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_basis.front_y <= ecam_pkg::rnd_single(i_trig.sp);
                        r_basis.right_x <= ecam_pkg::rnd_single(-i_trig.sy);
                        r_basis.right_z <= ecam_pkg::rnd_single(i_trig.cy);
                        r_basis.up_y    <= ecam_pkg::rnd_single(i_trig.cp);
                        r_idx           <= P_FRONT_X;
                        r_state         <= S_RUN;
                    end
                end
                S_RUN: begin
                    // Issue one product and retire the previous one
                    r_prod <= mul;
                    unique case (r_idx)
                        P_FRONT_Z: r_basis.front_x <= prod_rnd;
                        P_UP_X:    r_basis.front_z <= prod_rnd;
                        P_UP_Z:    r_basis.up_x    <= prod_rnd;
                        P_END:     r_basis.up_z    <= prod_rnd;
                        default:   ;
                    endcase
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == P_END) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_basis = r_basis;

endmodule
